[rtl/lsfb_pkg.sv]
// Shared types and constants for the sparkle-fade blender.
`timescale 1ns / 1ps

package lsfb_pkg;

  localparam int unsigned Pixels = 256;
  localparam int unsigned IdxW   = 8;
  localparam int unsigned DrawW  = 7;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned PixAw  = (Pixels > 1) ? $clog2(Pixels) : 1;

  typedef logic [ChanW-1:0] chan_t;

  localparam chan_t ChanMax = chan_t'(255);

  // Per-pixel fade phase codes
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhRise = 2'd1;
  localparam logic [1:0] PhFall = 2'd2;

  typedef struct packed {
    logic [1:0] phase;
    chan_t      level;
  } pix_st_t;

endpackage

[rtl/lsfb_blend.sv]
// One color channel blend: (base*(255-level) + sparkle*level) / 255, truncated.
`timescale 1ns / 1ps

module lsfb_blend import lsfb_pkg::*; (
  input  chan_t base_i,
  input  chan_t sparkle_i,
  input  chan_t level_i,
  output chan_t chan_o
);

  logic [2*ChanW-1:0] mix;
  logic [2*ChanW:0]   quo;

  assign mix = (2*ChanW)'(base_i) * (2*ChanW)'(ChanMax - level_i)
             + (2*ChanW)'(sparkle_i) * (2*ChanW)'(level_i);

  // Divide by 255: exact for mix <= 255*255
  assign quo = (2*ChanW+1)'(mix) + (2*ChanW+1)'(1)
             + (2*ChanW+1)'(mix[2*ChanW-1:ChanW]);

  assign chan_o = quo[2*ChanW-1:ChanW];

endmodule

[rtl/led_sparkle_fade_blend.sv]
// Top level of the sparkle-fade blender: per-pixel fade state and color blend.
//
//   channel   direction  handshake               payload
//   in        request    in_valid_i / in_stall_o   pixel_index_i, random_draw_i
//   out       result     out_valid_o / out_stall_i out_pixel_o, red_o, green_o, blue_o
//   cfg       APB write  psel, penable, pwrite    paddr, pwdata / prdata
//
// One request per cycle unless stalled; its result is registered as it leaves stage one.
// The state memory is read at acceptance and written when the request leaves
// stage one; a bypass register forwards that write to a following request for
// the same pixel. Reset clears the per-pixel valid bits, so every pixel reads
// idle at level zero until first written, and loads the register defaults.
// A stalled output holds; a full stage one then holds and in_stall_o rises.
`timescale 1ns / 1ps

module led_sparkle_fade_blend import lsfb_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // request channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [IdxW-1:0]  pixel_index_i,
  input  logic [DrawW-1:0] random_draw_i,
  // result channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [IdxW-1:0]  out_pixel_o,
  output chan_t            red_o,
  output chan_t            green_o,
  output chan_t            blue_o,
  // configuration
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [3:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam logic [1:0] RegBase    = 2'd0;
  localparam logic [1:0] RegSparkle = 2'd1;
  localparam logic [1:0] RegChance  = 2'd2;
  localparam logic [1:0] RegStep    = 2'd3;

  // ---------------- configuration registers ----------------
  logic [3*ChanW-1:0] base_q, sparkle_q;
  logic [DrawW-1:0]   chance_q;
  chan_t              step_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      sparkle_q <= '1;
      chance_q  <= DrawW'(5);
      step_q    <= chan_t'(5);
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegBase:    base_q    <= pwdata[3*ChanW-1:0];
        RegSparkle: sparkle_q <= pwdata[3*ChanW-1:0];
        RegChance:  chance_q  <= pwdata[DrawW-1:0];
        RegStep:    step_q    <= pwdata[ChanW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      RegBase:    prdata = 32'(base_q);
      RegSparkle: prdata = 32'(sparkle_q);
      RegChance:  prdata = 32'(chance_q);
      RegStep:    prdata = 32'(step_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------- handshake ----------------
  logic s1_v_q, out_v_q;
  logic in_acc, s1_adv;

  assign s1_adv     = s1_v_q && (!out_v_q || !out_stall_i);
  assign in_stall_o = s1_v_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_acc || s1_adv) s1_v_q <= in_acc;
      if (s1_adv || !out_stall_i) out_v_q <= s1_adv;
    end
  end

  // ---------------- stage one: request and state read ----------------
  logic [IdxW-1:0]  s1_idx_q;
  logic [DrawW-1:0] s1_draw_q;
  logic             s1_rng_q;
  logic             in_rng;
  logic [PixAw-1:0] rd_addr, wr_addr;
  logic             wr_en;
  pix_st_t          wr_st;

  assign in_rng  = ((IdxW+1)'(pixel_index_i) < (IdxW+1)'(Pixels));
  assign rd_addr = pixel_index_i[PixAw-1:0];
  assign wr_addr = s1_idx_q[PixAw-1:0];
  assign wr_en   = s1_adv && s1_rng_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_idx_q  <= pixel_index_i;
      s1_draw_q <= random_draw_i;
      s1_rng_q  <= in_rng;
    end
  end

  pix_st_t mem [Pixels];
  pix_st_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_st;
    if (in_acc) rd_q <= mem[rd_addr];
  end

  // Valid bits stand in for clearing the state memory
  logic [Pixels-1:0] vld_q;
  logic              vld_rd_q;
  logic              byp_q;
  pix_st_t           byp_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      byp_q    <= 1'b0;
    end else begin
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (in_acc) begin
        vld_rd_q <= vld_q[rd_addr];
        byp_q    <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  // Forward the state leaving stage one to a request for the same pixel
  always_ff @(posedge clk_i) begin
    if (in_acc) byp_st_q <= wr_st;
  end

  // ---------------- stage one: fade update ----------------
  pix_st_t          cur;
  logic [1:0]       ph;
  chan_t            lvl;
  logic [ChanW:0]   lvl_up;
  chan_t            blend_lvl;

  always_comb begin
    if (byp_q)         cur = byp_st_q;
    else if (vld_rd_q) cur = rd_q;
    else               cur = '0;

    ph     = cur.phase;
    lvl    = cur.level;
    lvl_up = (ChanW+1)'(cur.level) + (ChanW+1)'(step_q);

    // An unused phase code acts as idle
    if (!(ph inside {PhRise, PhFall})) begin
      ph = (s1_draw_q < chance_q) ? PhRise : PhIdle;
    end

    case (ph)
      PhRise: begin
        if (lvl_up >= (ChanW+1)'(ChanMax)) begin
          lvl = ChanMax;
          ph  = PhFall;
        end else begin
          lvl = lvl_up[ChanW-1:0];
        end
      end
      PhFall: begin
        if (lvl <= step_q) begin
          lvl = '0;
          ph  = PhIdle;
        end else begin
          lvl = lvl - step_q;
        end
      end
      default: ;
    endcase

    wr_st.phase = ph;
    wr_st.level = lvl;
    blend_lvl   = s1_rng_q ? lvl : '0;
  end

  // ---------------- blend and result register ----------------
  chan_t red_d, green_d, blue_d;

  lsfb_blend u_blend_red (
    .base_i    (base_q[3*ChanW-1:2*ChanW]),
    .sparkle_i (sparkle_q[3*ChanW-1:2*ChanW]),
    .level_i   (blend_lvl),
    .chan_o    (red_d)
  );

  lsfb_blend u_blend_green (
    .base_i    (base_q[2*ChanW-1:ChanW]),
    .sparkle_i (sparkle_q[2*ChanW-1:ChanW]),
    .level_i   (blend_lvl),
    .chan_o    (green_d)
  );

  lsfb_blend u_blend_blue (
    .base_i    (base_q[ChanW-1:0]),
    .sparkle_i (sparkle_q[ChanW-1:0]),
    .level_i   (blend_lvl),
    .chan_o    (blue_d)
  );

  logic [IdxW-1:0] out_pixel_q;
  chan_t           red_q, green_q, blue_q;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pixel_q <= s1_idx_q;
      red_q       <= red_d;
      green_q     <= green_d;
      blue_q      <= blue_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_pixel_o = out_pixel_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule
